// ===== hw/rtl/bri_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bri_pkg
// shared constants, codes and types of the bollinger / rsi signal block
// ---------------------------------------------------------------------------
package bri_pkg;

  localparam int PRICE_BITS      = 24;
  localparam int POS_BITS        = 32;
  localparam int CHG_BITS        = PRICE_BITS + 1;
  localparam int CFG_DATA_BITS   = 16;
  localparam int REG_INDEX_BITS  = 3;
  localparam int PERIOD_BITS     = 7;
  localparam int MULT_BITS       = 16;
  localparam int LEVEL_BITS      = 7;
  localparam int BAND_FRAC_BITS  = 12;
  localparam int RSI_SCALE       = 100;
  localparam int RSI_SCALE_BITS  = 7;

  localparam int DEF_MAX_BAND_PERIOD = 64;
  localparam int DEF_MAX_RSI_PERIOD  = 64;

  localparam logic [PERIOD_BITS-1:0] RST_BAND_PERIOD = 7'd20;
  localparam logic [MULT_BITS-1:0]   RST_BAND_MULT   = 16'd8192;
  localparam logic [PERIOD_BITS-1:0] RST_RSI_PERIOD  = 7'd14;
  localparam logic [LEVEL_BITS-1:0]  RST_RSI_UPPER   = 7'd70;
  localparam logic [LEVEL_BITS-1:0]  RST_RSI_LOWER   = 7'd30;

  typedef logic signed [1:0] signal_t;
  localparam signal_t SIG_HOLD = 2'sb00;
  localparam signal_t SIG_BUY  = 2'sb01;
  localparam signal_t SIG_SELL = 2'sb11;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_BAND_PERIOD = 3'd0,
    REG_BAND_MULT   = 3'd1,
    REG_RSI_PERIOD  = 3'd2,
    REG_RSI_UPPER   = 3'd3,
    REG_RSI_LOWER   = 3'd4
  } reg_index_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bri_tick_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bri_tick_if
// input channel: one price and the current position per transaction
// ---------------------------------------------------------------------------
interface bri_tick_if;
  logic                                valid;
  logic                                ready;
  logic [bri_pkg::PRICE_BITS-1:0]      price;
  logic signed [bri_pkg::POS_BITS-1:0] position;

  modport source (output valid, output price, output position, input ready);
  modport sink (input valid, input price, input position, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bri_trade_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bri_trade_if
// output channel: trade signal and warm-up flag per transaction
// ---------------------------------------------------------------------------
interface bri_trade_if;
  logic             valid;
  logic             ready;
  bri_pkg::signal_t signal;
  logic             warmed_up;

  modport source (output valid, output signal, output warmed_up, input ready);
  modport sink (input valid, input signal, input warmed_up, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bri_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bri_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module bri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bri_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bri_mul
// shared unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module bri_mul #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic [WIDTH-1:0]   a,
  input  wire logic [WIDTH-1:0]   b,
  output logic [2*WIDTH-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= (2*WIDTH)'(a) * (2*WIDTH)'(b);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bollinger_rsi_signal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bollinger_rsi_signal
// bollinger band and rsi mean-reversion trade signal over sliding windows
// ---------------------------------------------------------------------------
// channel  dir  handshake        payload
// tick     in   valid / ready    price, position
// trade    out  valid / ready    signal, warmed_up
// config   in   write_enable     reg_index, write_data
//
// one transaction at a time; a price runs the band and rsi multiplier steps only
// once the band window is full, before that it goes from update to the final step.
// windows live in two rams, read at the oldest entry on accept.
// reset clears counts, sums and the first-price flag; ram contents are kept.
// a result waiting on trade holds the next price in its final step.
// ---------------------------------------------------------------------------
module bollinger_rsi_signal #(
  parameter int MAX_BAND_PERIOD = bri_pkg::DEF_MAX_BAND_PERIOD,
  parameter int MAX_RSI_PERIOD  = bri_pkg::DEF_MAX_RSI_PERIOD
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                write_enable,
  input  wire logic [bri_pkg::REG_INDEX_BITS-1:0]  reg_index,
  input  wire logic [bri_pkg::CFG_DATA_BITS-1:0]   write_data,
  bri_tick_if.sink                                 tick,
  bri_trade_if.source                              trade
);

  localparam int PB     = bri_pkg::PRICE_BITS;
  localparam int CB     = $clog2(MAX_BAND_PERIOD + 1);
  localparam int CR     = $clog2(MAX_RSI_PERIOD + 1);
  localparam int AB     = MAX_BAND_PERIOD > 1 ? $clog2(MAX_BAND_PERIOD) : 1;
  localparam int AR     = MAX_RSI_PERIOD > 1 ? $clog2(MAX_RSI_PERIOD) : 1;
  localparam int SUM_W  = PB + CB;
  localparam int SQ_W   = 2*PB + CB;
  localparam int OPW    = SUM_W > 2*bri_pkg::MULT_BITS ? SUM_W : 2*bri_pkg::MULT_BITS;
  localparam int PROD_W = 2*OPW;
  localparam int CMP_W  = 3*OPW;
  localparam int GL_W   = PB + CR;
  localparam int RN_W   = GL_W + bri_pkg::RSI_SCALE_BITS;
  localparam int RT_W   = GL_W + 1 + bri_pkg::LEVEL_BITS;
  localparam int MSQ_W  = 2*bri_pkg::MULT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SQOLD, S_UPDATE, S_SS, S_NQLO, S_NQHI, S_NP,
    S_VAR, S_DIST, S_DD, S_RLO, S_RHI, S_SUMR, S_DONE
  } state_t;

  // configuration
  logic [bri_pkg::PERIOD_BITS-1:0] band_period;
  logic [bri_pkg::MULT_BITS-1:0]   band_multiplier;
  logic [bri_pkg::PERIOD_BITS-1:0] rsi_period;
  logic [bri_pkg::LEVEL_BITS-1:0]  rsi_upper;
  logic [bri_pkg::LEVEL_BITS-1:0]  rsi_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_period     <= bri_pkg::RST_BAND_PERIOD;
      band_multiplier <= bri_pkg::RST_BAND_MULT;
      rsi_period      <= bri_pkg::RST_RSI_PERIOD;
      rsi_upper       <= bri_pkg::RST_RSI_UPPER;
      rsi_lower       <= bri_pkg::RST_RSI_LOWER;
    end else if (write_enable) begin
      case (bri_pkg::reg_index_t'(reg_index))
        bri_pkg::REG_BAND_PERIOD: band_period     <= write_data[bri_pkg::PERIOD_BITS-1:0];
        bri_pkg::REG_BAND_MULT:   band_multiplier <= write_data[bri_pkg::MULT_BITS-1:0];
        bri_pkg::REG_RSI_PERIOD:  rsi_period      <= write_data[bri_pkg::PERIOD_BITS-1:0];
        bri_pkg::REG_RSI_UPPER:   rsi_upper       <= write_data[bri_pkg::LEVEL_BITS-1:0];
        bri_pkg::REG_RSI_LOWER:   rsi_lower       <= write_data[bri_pkg::LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturated periods
  logic [CB-1:0] nb;
  logic [CR-1:0] nr;

  always_comb begin
    if (32'(band_period) < 32'd2) begin
      nb = CB'(2);
    end else if (32'(band_period) > 32'(MAX_BAND_PERIOD)) begin
      nb = CB'(MAX_BAND_PERIOD);
    end else begin
      nb = CB'(band_period);
    end
    if (32'(rsi_period) < 32'd1) begin
      nr = CR'(1);
    end else if (32'(rsi_period) > 32'(MAX_RSI_PERIOD)) begin
      nr = CR'(MAX_RSI_PERIOD);
    end else begin
      nr = CR'(rsi_period);
    end
  end

  // state
  state_t                       state;
  logic [CB-1:0]                price_count;
  logic [CR-1:0]                change_count;
  logic [AB-1:0]                price_head;
  logic [AR-1:0]                change_head;
  logic [SUM_W-1:0]             price_sum;
  logic [SQ_W-1:0]              price_square_sum;
  logic [GL_W-1:0]              gain_sum;
  logic [GL_W-1:0]              loss_sum;
  logic [PB-1:0]                last_price;
  logic                         seen_first;
  logic                         out_valid;
  bri_pkg::signal_t             out_signal;
  logic                         out_warm;

  // item work registers
  logic [PB-1:0]                cur_price;
  logic signed [bri_pkg::POS_BITS-1:0] cur_pos;
  logic                         warm;
  logic [PROD_W-1:0]            s2;
  logic [PROD_W-1:0]            nq;
  logic [PROD_W-1:0]            var_q;
  logic [SUM_W-1:0]             np;
  logic [MSQ_W-1:0]             msq;
  logic [SUM_W-1:0]             gap;
  logic                         below;
  logic                         above;
  logic [PROD_W-1:0]            dd;
  logic [CMP_W-1:0]             rhs;
  logic [RN_W-1:0]              rnum;
  logic [GL_W:0]                rden;
  logic                         rsi_lo;
  logic                         rsi_hi;

  // rams
  logic [PB-1:0]                old_price;
  logic [bri_pkg::CHG_BITS-1:0] old_change;
  logic [AB-1:0]                price_waddr;
  logic [AR-1:0]                change_waddr;
  logic signed [PB:0]           delta;

  always_comb begin
    logic [CB:0] pa;
    logic [CR:0] ca;
    pa = (CB+1)'(price_head) + (CB+1)'(price_count);
    if (pa >= (CB+1)'(MAX_BAND_PERIOD)) begin
      pa = pa - (CB+1)'(MAX_BAND_PERIOD);
    end
    price_waddr = pa[AB-1:0];
    ca = (CR+1)'(change_head) + (CR+1)'(change_count);
    if (ca >= (CR+1)'(MAX_RSI_PERIOD)) begin
      ca = ca - (CR+1)'(MAX_RSI_PERIOD);
    end
    change_waddr = ca[AR-1:0];
  end

  assign delta = $signed({1'b0, cur_price}) - $signed({1'b0, last_price});

  bri_ram #(.WIDTH(PB), .DEPTH(MAX_BAND_PERIOD)) u_price_ram (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (price_waddr),
    .wdata (cur_price),
    .raddr (price_head),
    .rdata (old_price)
  );

  bri_ram #(.WIDTH(bri_pkg::CHG_BITS), .DEPTH(MAX_RSI_PERIOD)) u_change_ram (
    .clk   (clk),
    .we    (state == S_UPDATE && seen_first),
    .waddr (change_waddr),
    .wdata (delta),
    .raddr (change_head),
    .rdata (old_change)
  );

  // shared multiplier
  logic [OPW-1:0]    mul_a;
  logic [OPW-1:0]    mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sq_ext;

  assign sq_ext = PROD_W'(price_square_sum);

  always_comb begin
    unique case (state)
      S_LOAD:  begin mul_a = OPW'(cur_price); mul_b = OPW'(cur_price); end
      S_SQOLD: begin mul_a = OPW'(old_price); mul_b = OPW'(old_price); end
      S_SS:    begin mul_a = OPW'(price_sum); mul_b = OPW'(price_sum); end
      S_NQLO:  begin mul_a = OPW'(nb); mul_b = sq_ext[OPW-1:0]; end
      S_NQHI:  begin mul_a = OPW'(nb); mul_b = sq_ext[PROD_W-1:OPW]; end
      S_NP:    begin mul_a = OPW'(nb); mul_b = OPW'(cur_price); end
      S_VAR:   begin mul_a = OPW'(band_multiplier); mul_b = OPW'(band_multiplier); end
      S_DD:    begin mul_a = OPW'(gap); mul_b = OPW'(gap); end
      S_RLO:   begin mul_a = OPW'(msq); mul_b = var_q[OPW-1:0]; end
      S_RHI:   begin mul_a = OPW'(msq); mul_b = var_q[PROD_W-1:OPW]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  bri_mul #(.WIDTH(OPW)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // window update terms
  logic          price_drop;
  logic          change_drop;
  logic          delta_up;
  logic [PB-1:0] delta_mag;
  logic          old_up;
  logic [PB-1:0] old_mag;
  logic [CB-1:0] price_count_next;
  logic [CMP_W-1:0] lhs;
  logic          out_band;
  logic          pos_zero;
  logic          pos_long;

  always_comb begin
    logic signed [PB:0] oc;
    logic signed [PB:0] nd;
    price_drop  = price_count >= nb;
    change_drop = seen_first && (change_count >= nr);
    delta_up    = !delta[PB] && (delta != '0);
    nd          = -delta;
    delta_mag   = delta[PB] ? nd[PB-1:0] : delta[PB-1:0];
    oc          = $signed(old_change);
    old_up      = !oc[PB] && (oc != '0);
    nd          = -oc;
    old_mag     = oc[PB] ? nd[PB-1:0] : oc[PB-1:0];
    price_count_next = price_count + CB'(1) - CB'(price_drop);
  end

  assign lhs      = CMP_W'(dd) << (2*bri_pkg::BAND_FRAC_BITS);
  assign out_band = lhs > rhs;
  assign pos_zero = cur_pos == '0;
  assign pos_long = !cur_pos[bri_pkg::POS_BITS-1] && (cur_pos != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      price_count      <= '0;
      change_count     <= '0;
      price_head       <= '0;
      change_head      <= '0;
      price_sum        <= '0;
      price_square_sum <= '0;
      gain_sum         <= '0;
      loss_sum         <= '0;
      last_price       <= '0;
      seen_first       <= 1'b0;
      out_valid        <= 1'b0;
      out_signal       <= bri_pkg::SIG_HOLD;
      out_warm         <= 1'b0;
    end else begin
      if (trade.valid && trade.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            cur_price <= tick.price;
            cur_pos   <= tick.position;
            state     <= S_LOAD;
          end
        end
        S_LOAD: state <= S_SQOLD;
        S_SQOLD: begin
          price_square_sum <= price_square_sum + SQ_W'(prod);
          state            <= S_UPDATE;
        end
        S_UPDATE: begin
          if (price_drop) begin
            price_square_sum <= price_square_sum - SQ_W'(prod);
            price_head <= (price_head == AB'(MAX_BAND_PERIOD - 1)) ? '0 : price_head + AB'(1);
          end
          price_sum <= price_sum + SUM_W'(cur_price)
                       - (price_drop ? SUM_W'(old_price) : SUM_W'(0));
          price_count <= price_count_next;
          if (seen_first) begin
            gain_sum <= gain_sum + (delta_up ? GL_W'(delta_mag) : GL_W'(0))
                        - ((change_drop && old_up) ? GL_W'(old_mag) : GL_W'(0));
            loss_sum <= loss_sum + (delta_up ? GL_W'(0) : GL_W'(delta_mag))
                        - ((change_drop && !old_up) ? GL_W'(old_mag) : GL_W'(0));
            change_count <= change_count + CR'(1) - CR'(change_drop);
            if (change_drop) begin
              change_head <= (change_head == AR'(MAX_RSI_PERIOD - 1)) ? '0
                             : change_head + AR'(1);
            end
          end
          last_price <= cur_price;
          seen_first <= 1'b1;
          warm       <= price_count_next >= nb;
          state      <= (price_count_next >= nb) ? S_SS : S_DONE;
        end
        S_SS: begin
          if (loss_sum == '0) begin
            rnum <= RN_W'(bri_pkg::RSI_SCALE);
            rden <= (GL_W+1)'(1);
          end else begin
            rnum <= RN_W'(gain_sum) * RN_W'(bri_pkg::RSI_SCALE);
            rden <= (GL_W+1)'(gain_sum) + (GL_W+1)'(loss_sum);
          end
          state <= S_NQLO;
        end
        S_NQLO: begin
          s2     <= prod;
          rsi_lo <= RT_W'(rnum) < RT_W'(rsi_lower) * RT_W'(rden);
          rsi_hi <= RT_W'(rnum) > RT_W'(rsi_upper) * RT_W'(rden);
          state  <= S_NQHI;
        end
        S_NQHI: begin
          nq    <= prod;
          state <= S_NP;
        end
        S_NP: begin
          nq    <= nq + {prod[OPW-1:0], {OPW{1'b0}}};
          state <= S_VAR;
        end
        S_VAR: begin
          var_q <= (nq > s2) ? nq - s2 : '0;
          np    <= prod[SUM_W-1:0];
          state <= S_DIST;
        end
        S_DIST: begin
          msq   <= prod[MSQ_W-1:0];
          below <= price_sum > np;
          above <= np > price_sum;
          gap   <= (price_sum > np) ? price_sum - np : np - price_sum;
          state <= S_DD;
        end
        S_DD: state <= S_RLO;
        S_RLO: begin
          dd    <= prod;
          state <= S_RHI;
        end
        S_RHI: begin
          rhs   <= CMP_W'(prod);
          state <= S_SUMR;
        end
        S_SUMR: begin
          rhs   <= rhs + (CMP_W'(prod) << OPW);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || trade.ready) begin
            out_valid <= 1'b1;
            out_warm  <= warm;
            if (warm && below && out_band && rsi_lo && pos_zero) begin
              out_signal <= bri_pkg::SIG_BUY;
            end else if (warm && above && out_band && rsi_hi && pos_long) begin
              out_signal <= bri_pkg::SIG_SELL;
            end else begin
              out_signal <= bri_pkg::SIG_HOLD;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tick.ready      = state == S_IDLE;
  assign trade.valid     = out_valid;
  assign trade.signal    = out_signal;
  assign trade.warmed_up = out_warm;

`ifndef SYNTHESIS
  a_sig_needs_warm : assert property (@(posedge clk) disable iff (rst)
    (trade.valid && trade.signal != bri_pkg::SIG_HOLD) |-> trade.warmed_up)
    else $error("trade signal given before the band window is full");

  a_sig_code : assert property (@(posedge clk) disable iff (rst)
    trade.valid |-> (trade.signal == bri_pkg::SIG_HOLD || trade.signal == bri_pkg::SIG_BUY
                     || trade.signal == bri_pkg::SIG_SELL))
    else $error("trade signal out of range");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |=> (price_count != '0 && 32'(price_count) <= MAX_BAND_PERIOD
                             && 32'(change_count) <= MAX_RSI_PERIOD))
    else $error("window count out of bounds after update");

  a_seen_sticky : assert property (@(posedge clk) disable iff (rst)
    seen_first |=> seen_first)
    else $error("first price flag dropped");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_bollinger_rsi_signal.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bollinger_rsi_signal
// self-checking bench: price ticks go in with random gaps, each trade result
// is checked against a cycle-free model of the band and rsi windows
// ---------------------------------------------------------------------------
module tb_bollinger_rsi_signal;
  import bri_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [REG_INDEX_BITS-1:0] reg_index = '0;
  logic [CFG_DATA_BITS-1:0] write_data = '0;

  bri_tick_if tick ();
  bri_trade_if trade ();

  bollinger_rsi_signal u_dut (
    .clk(clk), .rst(rst), .write_enable(write_enable), .reg_index(reg_index),
    .write_data(write_data), .tick(tick.sink), .trade(trade.source)
  );

  always #2 clk = ~clk;

  // model state
  logic [6:0]  m_band_period, m_rsi_period, m_rsi_upper, m_rsi_lower;
  logic [15:0] m_mult;
  logic [23:0] price_win[64];
  logic signed [24:0] change_win[64];
  int unsigned price_cnt, change_cnt, price_head, change_head;
  logic [63:0] price_sum, square_sum, gain_sum, loss_sum;
  logic [23:0] last_price;
  bit seen_first;

  typedef struct packed {
    signal_t signal;
    logic    warmed_up;
  } trade_t;
  trade_t expected_trades[$];

  int errors = 0;
  int n_ticks = 0, n_trades = 0, n_buys = 0, n_sells = 0;
  bit calm = 1'b0;

  task automatic model_reset();
    m_band_period = RST_BAND_PERIOD; m_mult = RST_BAND_MULT;
    m_rsi_period = RST_RSI_PERIOD; m_rsi_upper = RST_RSI_UPPER;
    m_rsi_lower = RST_RSI_LOWER;
    price_cnt = 0; change_cnt = 0; price_head = 0; change_head = 0;
    price_sum = 0; square_sum = 0; gain_sum = 0; loss_sum = 0;
    last_price = 0; seen_first = 1'b0;
  endtask

  function automatic bit beyond_band(logic [63:0] gap, logic [63:0] var_q);
    logic [127:0] lhs, rhs;
    logic [63:0] d, mm;
    d = gap << 12;
    mm = 64'(m_mult) * 64'(m_mult);
    lhs = 128'(d) * 128'(d);
    rhs = 128'(mm) * 128'(var_q);
    return lhs > rhs;
  endfunction

  function automatic trade_t predict_trade(logic [23:0] p, logic signed [31:0] pos);
    int unsigned nb, nr;
    logic signed [24:0] chg, old_chg;
    logic [63:0] old_p, nq, s2, var_q, np, rnum, rden;
    trade_t t;
    nb = m_band_period < 2 ? 2 : (m_band_period > 64 ? 64 : m_band_period);
    nr = m_rsi_period < 1 ? 1 : (m_rsi_period > 64 ? 64 : m_rsi_period);
    if (!seen_first) begin
      seen_first = 1'b1;
    end else begin
      chg = $signed({1'b0, p}) - $signed({1'b0, last_price});
      if (change_cnt >= nr && change_cnt > 0) begin
        old_chg = change_win[change_head];
        if (old_chg > 0) gain_sum -= 64'(old_chg);
        else loss_sum -= 64'(-old_chg);
        change_head = (change_head + 1) % 64;
        change_cnt--;
      end
      change_win[(change_head + change_cnt) % 64] = chg;
      if (chg > 0) gain_sum += 64'(chg);
      else loss_sum += 64'(-chg);
      change_cnt++;
    end
    if (price_cnt >= nb) begin
      old_p = price_win[price_head];
      price_sum -= old_p;
      square_sum -= old_p * old_p;
      price_head = (price_head + 1) % 64;
      price_cnt--;
    end
    price_win[(price_head + price_cnt) % 64] = p;
    price_sum += 64'(p);
    square_sum += 64'(p) * 64'(p);
    price_cnt++;
    last_price = p;
    t.signal = SIG_HOLD;
    t.warmed_up = price_cnt >= nb;
    if (t.warmed_up) begin
      nq = 64'(nb) * square_sum;
      s2 = price_sum * price_sum;
      var_q = nq > s2 ? nq - s2 : 64'd0;
      np = 64'(nb) * 64'(p);
      if (loss_sum == 0) begin
        rnum = 100; rden = 1;
      end else begin
        rnum = 100 * gain_sum; rden = gain_sum + loss_sum;
      end
      if (price_sum > np && beyond_band(price_sum - np, var_q)
          && rnum < 64'(m_rsi_lower) * rden && pos == 0) begin
        t.signal = SIG_BUY;
      end else if (np > price_sum && beyond_band(np - price_sum, var_q)
                   && rnum > 64'(m_rsi_upper) * rden && pos > 0) begin
        t.signal = SIG_SELL;
      end
    end
    return t;
  endfunction

  task automatic write_reg(reg_index_t idx, int unsigned val);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= 16'(val);
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_BAND_PERIOD: m_band_period = 7'(val);
      REG_BAND_MULT:   m_mult = 16'(val);
      REG_RSI_PERIOD:  m_rsi_period = 7'(val);
      REG_RSI_UPPER:   m_rsi_upper = 7'(val);
      REG_RSI_LOWER:   m_rsi_lower = 7'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    tick.valid <= 1'b0;
    while (expected_trades.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_tick(logic [23:0] p, logic signed [31:0] pos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      tick.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.price <= p;
    tick.position <= pos;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    expected_trades.push_back(predict_trade(p, pos));
    n_ticks++;
  endtask

  // trade sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      trade.ready <= 1'b0;
    end else begin
      trade.ready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (trade.valid && trade.ready) begin
        if (expected_trades.size() == 0) begin
          $error("trade transaction with nothing expected");
          errors++;
        end else begin
          trade_t e;
          e = expected_trades.pop_front();
          if (trade.signal !== e.signal) begin
            $error("signal expected %0d got %0d", e.signal, trade.signal);
            errors++;
          end
          if (trade.warmed_up !== e.warmed_up) begin
            $error("warmed_up expected %0d got %0d", e.warmed_up, trade.warmed_up);
            errors++;
          end
          n_trades++;
          if (trade.signal == SIG_BUY) n_buys++;
          if (trade.signal == SIG_SELL) n_sells++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_position();
    case ($urandom_range(0, 5))
      0, 1: return 0;
      2: return $urandom_range(1, 1000);
      3: return -$signed(32'($urandom_range(1, 1000)));
      default: return $urandom;
    endcase
  endfunction

  // random walk with occasional spikes and random jumps so bands are crossed
  task automatic run_walk(int count, int unsigned base, int unsigned step);
    int unsigned p;
    int unsigned q;
    p = base;
    for (int i = 0; i < count; i++) begin
      q = $urandom_range(0, 19);
      if (q == 0) p = p + step * 8;
      else if (q == 1) p = p > step * 8 ? p - step * 8 : 0;
      else if (q < 4) p = $urandom;
      else p = p + $urandom_range(0, 2 * step) - step;
      if (p > 24'hFFFFFF || $signed(p) < 0) p = base;
      send_tick(p[23:0], rand_position());
    end
  endtask

  task automatic test_directed_extremes();
    write_reg(REG_BAND_PERIOD, 2);
    write_reg(REG_RSI_PERIOD, 1);
    send_tick(24'h000000, 0);
    send_tick(24'hFFFFFF, 0);
    send_tick(24'hFFFFFF, 32'sh7FFFFFFF);
    send_tick(24'h000000, 0);
    send_tick(24'h000000, 0);
    send_tick(24'hFFFFFF, 1);
    send_tick(24'h000001, 0);
    send_tick(24'hFFFFFE, 1);
    send_tick(24'h555555, -1);
    send_tick(24'hAAAAAA, 32'sh80000000);
    send_tick(24'h000000, 0);
    send_tick(24'hFFFFFF, 5);
    drain();
  endtask

  task automatic test_thresholds_and_saturation();
    write_reg(REG_BAND_PERIOD, 0);
    write_reg(REG_RSI_PERIOD, 0);
    write_reg(REG_BAND_MULT, 0);
    write_reg(REG_RSI_UPPER, 0);
    write_reg(REG_RSI_LOWER, 100);
    run_walk(12, 1000, 50);
    drain();
    write_reg(REG_BAND_PERIOD, 127);
    write_reg(REG_RSI_PERIOD, 127);
    write_reg(REG_RSI_UPPER, 127);
    write_reg(REG_RSI_LOWER, 127);
    write_reg(REG_BAND_MULT, 16'hFFFF);
    drain();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_BAND_PERIOD, ph == 0 ? 64 : $urandom_range(2, 24));
      write_reg(REG_RSI_PERIOD, ph == 1 ? 64 : $urandom_range(1, 20));
      write_reg(REG_BAND_MULT, ph == 2 ? 16'hFFFF : $urandom_range(0, 12000));
      write_reg(REG_RSI_UPPER, $urandom_range(40, 100));
      write_reg(REG_RSI_LOWER, $urandom_range(0, 60));
      if (ph == 9) calm = 1'b1;
      run_walk(ph == 0 ? 130 : 100, $urandom_range(100, 16000000), $urandom_range(1, 3000));
      drain();
    end
  endtask

  initial begin
    tick.valid = 1'b0;
    tick.price = '0;
    tick.position = '0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_thresholds_and_saturation();
    test_random_settings();
    $display("covered %0d ticks, %0d trades checked (%0d buy, %0d sell)",
             n_ticks, n_trades, n_buys, n_sells);
    if (errors == 0) begin
      $display("tb_bollinger_rsi_signal: done, clean");
    end else begin
      $display("tb_bollinger_rsi_signal: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_bollinger_rsi_signal: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/bri_pkg.sv
hw/rtl/bri_tick_if.sv
hw/rtl/bri_trade_if.sv
hw/rtl/bri_ram.sv
hw/rtl/bri_mul.sv
hw/rtl/bollinger_rsi_signal.sv
tb/tb_bollinger_rsi_signal.sv
